// ===== design/prba_pkg.sv =====
// ----------------------------------------------------------------------------
// prba_pkg: shared types and constants for the range argument parser
// Holds the classified beat type, the parse phases and the radix codes.
// ----------------------------------------------------------------------------
package prba_pkg;

    typedef enum logic [6:0] {
        ST_SEEK      = 7'b0000001,
        ST_N1_START  = 7'b0000010,
        ST_N1_PREFIX = 7'b0000100,
        ST_N1_DIGITS = 7'b0001000,
        ST_N2_START  = 7'b0010000,
        ST_N2_PREFIX = 7'b0100000,
        ST_N2_DIGITS = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } t_radix;

    typedef struct packed {
        logic       is_end;
        logic       is_comma;
        logic       is_dash;
        logic       is_x;
        logic       is_zero_char;
        logic       is_dec;
        logic       dig_ok;
        logic [5:0] digit;
    } t_beat;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_LX    = 8'h78;

endpackage

// ===== design/parse_block_range_argument.sv =====
// ----------------------------------------------------------------------------
// parse_block_range_argument: block range argument parser
// Parses ",<start>-<stop>" out of a byte stream, one result per zero byte.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready carry one byte of text per beat on
// i_char_code. A zero byte closes the argument.
// Output channel: o_valid / i_ready carry one result per closed argument:
// o_parse_failed, o_start_block and o_stop_block (numbers zero on failure).
// Numbers take C prefixes (0x hex, leading 0 octal, else decimal) and may
// not exceed 2^VALUE_WIDTH - 1.
// Throughput: one byte per cycle while the receiver keeps taking results, set
// by the single shift-add and limit compare done per beat in the back sequencer.
// With the queue empty, the zero byte's beat goes from the intake register
// through the queue into the result register, which then raises o_valid.
// Reset: synchronous, active low; clears the queue, the parse state and the
// result valid. No clearing pass is needed.
// Receiver stall: the result register holds and the back part keeps parsing
// until the next zero byte reaches it; that beat waits at the queue head, and
// once the two-entry queue and the intake register fill, o_ready drops.
// ----------------------------------------------------------------------------
module parse_block_range_argument #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_char_code,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_parse_failed,
    output logic [VALUE_WIDTH-1:0] o_start_block,
    output logic [VALUE_WIDTH-1:0] o_stop_block
);

    logic            push;
    logic            queue_ready;
    logic            head_valid;
    logic            pop;
    prba_pkg::t_beat front_beat;
    prba_pkg::t_beat head_beat;

    prba_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_code   (i_char_code),
        .o_push        (push),
        .o_beat        (front_beat),
        .i_queue_ready (queue_ready)
    );

    prba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (front_beat),
        .o_ready (queue_ready),
        .o_valid (head_valid),
        .o_beat  (head_beat),
        .i_pop   (pop)
    );

    prba_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_beat_valid   (head_valid),
        .i_beat         (head_beat),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_parse_failed (o_parse_failed),
        .o_start_block  (o_start_block),
        .o_stop_block   (o_stop_block)
    );

endmodule

// ===== design/prba_front.sv =====
// ----------------------------------------------------------------------------
// prba_front: byte intake and classification
// Registers each accepted byte as a classified beat and hands it to the queue.
// ----------------------------------------------------------------------------
module prba_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_char_code,
    output logic             o_push,
    output prba_pkg::t_beat  o_beat,
    input  logic             i_queue_ready
);

    logic            r_valid;
    prba_pkg::t_beat r_beat;
    prba_pkg::t_beat n_beat;

    always_comb begin
        n_beat              = '0;
        n_beat.is_end       = (i_char_code == prba_pkg::CH_NUL);
        n_beat.is_comma     = (i_char_code == prba_pkg::CH_COMMA);
        n_beat.is_dash      = (i_char_code == prba_pkg::CH_DASH);
        n_beat.is_x         = (i_char_code == prba_pkg::CH_LX) ||
                              (i_char_code == prba_pkg::CH_UX);
        n_beat.is_zero_char = (i_char_code == prba_pkg::CH_ZERO);
        n_beat.is_dec       = (i_char_code >= prba_pkg::CH_ZERO) &&
                              (i_char_code <= prba_pkg::CH_NINE);
        if (n_beat.is_dec) begin
            n_beat.dig_ok = 1'b1;
            n_beat.digit  = 6'(i_char_code - prba_pkg::CH_ZERO);
        end else if (i_char_code >= prba_pkg::CH_UA && i_char_code <= prba_pkg::CH_UZ) begin
            n_beat.dig_ok = 1'b1;
            n_beat.digit  = 6'(i_char_code - prba_pkg::CH_UA) + 6'd10;
        end else if (i_char_code >= prba_pkg::CH_LA && i_char_code <= prba_pkg::CH_LZ) begin
            n_beat.dig_ok = 1'b1;
            n_beat.digit  = 6'(i_char_code - prba_pkg::CH_LA) + 6'd10;
        end
    end

    assign o_push  = r_valid && i_queue_ready;
    assign o_ready = !r_valid || i_queue_ready;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

endmodule

// ===== design/prba_queue.sv =====
// ----------------------------------------------------------------------------
// prba_queue: short beat queue between the front and back parts
// First-in first-out store of classified beats; lets either side stall.
// ----------------------------------------------------------------------------
module prba_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  prba_pkg::t_beat  i_beat,
    output logic             o_ready,
    output logic             o_valid,
    output prba_pkg::t_beat  o_beat,
    input  logic             i_pop
);

    localparam int PTR_W = (prba_pkg::QUEUE_DEPTH > 1) ? $clog2(prba_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(prba_pkg::QUEUE_DEPTH + 1);

    prba_pkg::t_beat  r_mem [prba_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_W'(prba_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(prba_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

endmodule

// ===== design/prba_back.sv =====
// ----------------------------------------------------------------------------
// prba_back: parse sequencer and result register
// Walks the grammar one beat a cycle unless stalled and registers each result.
// ----------------------------------------------------------------------------
module prba_back #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_beat_valid,
    input  prba_pkg::t_beat        i_beat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_parse_failed,
    output logic [VALUE_WIDTH-1:0] o_start_block,
    output logic [VALUE_WIDTH-1:0] o_stop_block
);

    localparam logic [VALUE_WIDTH-1:0] LIM   = '1;
    localparam logic [VALUE_WIDTH-1:0] Q_DEC = LIM / 10;
    localparam logic [VALUE_WIDTH-1:0] Q_OCT = LIM / 8;
    localparam logic [VALUE_WIDTH-1:0] Q_HEX = LIM / 16;
    localparam logic [5:0]             R_DEC = 6'(LIM % 10);
    localparam logic [5:0]             R_OCT = 6'(LIM % 8);
    localparam logic [5:0]             R_HEX = 6'(LIM % 16);

    prba_pkg::t_phase       r_phase, n_phase;
    prba_pkg::t_radix       r_radix, n_radix, eff_radix;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [VALUE_WIDTH-1:0] r_first, n_first;
    logic                   r_err, n_err;
    logic                   r_out_valid;

    logic                   fits;
    logic                   no_ovf;
    logic [VALUE_WIDTH-1:0] mac;
    logic [VALUE_WIDTH-1:0] dig_ext;
    logic                   dash_ok;
    logic                   take_result;
    logic                   ok;

    assign dig_ext = VALUE_WIDTH'(i_beat.digit);

    always_comb begin
        if (r_phase == prba_pkg::ST_N1_PREFIX || r_phase == prba_pkg::ST_N2_PREFIX) begin
            eff_radix = prba_pkg::RADIX_OCT;
        end else if (r_phase == prba_pkg::ST_N2_START) begin
            eff_radix = prba_pkg::RADIX_DEC;
        end else begin
            eff_radix = r_radix;
        end
    end

    always_comb begin
        case (eff_radix)
            prba_pkg::RADIX_OCT: begin
                fits   = i_beat.dig_ok && (i_beat.digit < 6'd8);
                no_ovf = (r_value < Q_OCT) || (r_value == Q_OCT && i_beat.digit <= R_OCT);
                mac    = (r_value << 3) | dig_ext;
            end
            prba_pkg::RADIX_HEX: begin
                fits   = i_beat.dig_ok && (i_beat.digit < 6'd16);
                no_ovf = (r_value < Q_HEX) || (r_value == Q_HEX && i_beat.digit <= R_HEX);
                mac    = (r_value << 4) | dig_ext;
            end
            default: begin
                fits   = i_beat.dig_ok && (i_beat.digit < 6'd10);
                no_ovf = (r_value < Q_DEC) || (r_value == Q_DEC && i_beat.digit <= R_DEC);
                mac    = (r_value << 3) + (r_value << 1) + dig_ext;
            end
        endcase
    end

    assign dash_ok = (r_phase == prba_pkg::ST_N1_DIGITS) || (r_phase == prba_pkg::ST_N1_PREFIX);
    assign o_pop   = i_beat_valid && (!i_beat.is_end || !r_out_valid || i_ready);
    assign take_result = o_pop && i_beat.is_end;
    assign ok = !r_err && (r_phase == prba_pkg::ST_N2_START ||
                           r_phase == prba_pkg::ST_N2_PREFIX ||
                           r_phase == prba_pkg::ST_N2_DIGITS);

    always_comb begin
        n_phase = r_phase;
        n_radix = r_radix;
        n_value = r_value;
        n_first = r_first;
        n_err   = r_err;
        if (i_beat.is_end) begin
            n_phase = prba_pkg::ST_SEEK;
            n_radix = prba_pkg::RADIX_DEC;
            n_value = '0;
            n_first = '0;
            n_err   = 1'b0;
        end else if (!r_err) begin
            unique case (r_phase)
                prba_pkg::ST_SEEK: begin
                    if (i_beat.is_comma) begin
                        n_phase = prba_pkg::ST_N1_START;
                    end
                end
                prba_pkg::ST_N1_START: begin
                    n_value = '0;
                    if (!i_beat.is_dec) begin
                        n_err = 1'b1;
                    end else if (i_beat.is_zero_char) begin
                        n_phase = prba_pkg::ST_N1_PREFIX;
                    end else begin
                        n_radix = prba_pkg::RADIX_DEC;
                        n_value = dig_ext;
                        n_phase = prba_pkg::ST_N1_DIGITS;
                    end
                end
                default: begin
                    if (r_phase == prba_pkg::ST_N2_START && i_beat.is_zero_char) begin
                        n_value = '0;
                        n_phase = prba_pkg::ST_N2_PREFIX;
                    end else if ((r_phase == prba_pkg::ST_N1_PREFIX ||
                                  r_phase == prba_pkg::ST_N2_PREFIX) && i_beat.is_x) begin
                        n_radix = prba_pkg::RADIX_HEX;
                        n_phase = (r_phase == prba_pkg::ST_N1_PREFIX) ?
                                  prba_pkg::ST_N1_DIGITS : prba_pkg::ST_N2_DIGITS;
                    end else begin
                        n_radix = eff_radix;
                        n_phase = (r_phase == prba_pkg::ST_N1_PREFIX ||
                                   r_phase == prba_pkg::ST_N1_DIGITS) ?
                                  prba_pkg::ST_N1_DIGITS : prba_pkg::ST_N2_DIGITS;
                        if (fits) begin
                            if (no_ovf) begin
                                n_value = mac;
                            end else begin
                                n_err = 1'b1;
                            end
                        end else if (dash_ok && i_beat.is_dash) begin
                            n_first = r_value;
                            n_value = '0;
                            n_radix = prba_pkg::RADIX_DEC;
                            n_phase = prba_pkg::ST_N2_START;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= prba_pkg::ST_SEEK;
            r_radix     <= prba_pkg::RADIX_DEC;
            r_value     <= '0;
            r_first     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_radix <= n_radix;
                r_value <= n_value;
                r_first <= n_first;
                r_err   <= n_err;
            end
            if (take_result) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_result) begin
            o_parse_failed <= !ok;
            o_start_block  <= ok ? r_first : '0;
            o_stop_block   <= ok ? r_value : '0;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== design/prba_checker.sv =====
// ----------------------------------------------------------------------------
// prba_checker: port-level checks for the range argument parser
// Watches the top-level ports and flags result-channel misbehavior.
// ----------------------------------------------------------------------------
module prba_checker #(
    parameter int VALUE_WIDTH = 64
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic                   o_parse_failed,
    input logic [VALUE_WIDTH-1:0] o_start_block,
    input logic [VALUE_WIDTH-1:0] o_stop_block
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped before accept");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_parse_failed) && $stable(o_start_block) &&
                                $stable(o_stop_block))
        else $error("result payload changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_parse_failed |-> (o_start_block == '0) && (o_stop_block == '0))
        else $error("failed result carries nonzero numbers");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result shown before any byte");

endmodule

bind parse_block_range_argument prba_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_prba_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the block range argument parser
// Streams argument text into the parser a beat at a time, mostly well-formed
// ",start-stop" arguments in all three bases plus noise and corrupted text,
// and checks every result against a cycle-free model of the parse held in a
// small scoreboard. Both handshakes idle in random bursts; a long receiver
// hold-off backs the parser up, and the sender drains it now and then.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VW           = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1050;
    localparam int TAIL_BYTES   = 200;
    localparam int HOLD_CYCLES  = 300;

    typedef logic [VW-1:0] t_value;

    typedef struct packed {
        logic   failed;
        t_value start_v;
        t_value stop_v;
    } t_range_result;

    class range_scoreboard;
        prba_pkg::t_phase phase;
        prba_pkg::t_radix radix;
        t_value           running;
        t_value           first_num;
        bit               err;
        t_range_result    expected_q[$];
        int               mismatches;

        function new();
            clear_state();
            mismatches = 0;
        endfunction

        function void clear_state();
            phase     = prba_pkg::ST_SEEK;
            radix     = prba_pkg::RADIX_DEC;
            running   = '0;
            first_num = '0;
            err       = 1'b0;
        endfunction

        function int digit_value(logic [7:0] b);
            if (b >= prba_pkg::CH_ZERO && b <= prba_pkg::CH_NINE)
                return int'(b - prba_pkg::CH_ZERO);
            if (b >= prba_pkg::CH_UA && b <= prba_pkg::CH_UZ)
                return int'(b - prba_pkg::CH_UA) + 10;
            if (b >= prba_pkg::CH_LA && b <= prba_pkg::CH_LZ)
                return int'(b - prba_pkg::CH_LA) + 10;
            return 99;
        endfunction

        function void take_digit(logic [7:0] b);
            int            base;
            int            d;
            logic [VW+7:0] wide;
            base = (radix == prba_pkg::RADIX_HEX) ? 16 :
                   (radix == prba_pkg::RADIX_OCT) ? 8 : 10;
            d    = digit_value(b);
            if (d < base) begin
                wide = {8'd0, running} * (VW+8)'(base) + (VW+8)'(d);
                if (wide > {8'd0, {VW{1'b1}}}) begin
                    err = 1'b1;
                end else begin
                    running = wide[VW-1:0];
                end
            end else if (phase == prba_pkg::ST_N1_DIGITS && b == prba_pkg::CH_DASH) begin
                first_num = running;
                running   = '0;
                radix     = prba_pkg::RADIX_DEC;
                phase     = prba_pkg::ST_N2_START;
            end else begin
                err = 1'b1;
            end
        endfunction

        function void note_byte(logic [7:0] b);
            t_range_result r;
            bit            ok;
            if (b == prba_pkg::CH_NUL) begin
                ok = !err && (phase == prba_pkg::ST_N2_START ||
                              phase == prba_pkg::ST_N2_PREFIX ||
                              phase == prba_pkg::ST_N2_DIGITS);
                r.failed  = !ok;
                r.start_v = ok ? first_num : '0;
                r.stop_v  = ok ? running : '0;
                expected_q.push_back(r);
                clear_state();
                return;
            end
            if (err) return;
            case (phase) inside
                prba_pkg::ST_SEEK: begin
                    if (b == prba_pkg::CH_COMMA) phase = prba_pkg::ST_N1_START;
                end
                prba_pkg::ST_N1_START: begin
                    running = '0;
                    if (b < prba_pkg::CH_ZERO || b > prba_pkg::CH_NINE) begin
                        err = 1'b1;
                    end else if (b == prba_pkg::CH_ZERO) begin
                        phase = prba_pkg::ST_N1_PREFIX;
                    end else begin
                        radix   = prba_pkg::RADIX_DEC;
                        running = VW'(b - prba_pkg::CH_ZERO);
                        phase   = prba_pkg::ST_N1_DIGITS;
                    end
                end
                prba_pkg::ST_N2_START: begin
                    running = '0;
                    if (b == prba_pkg::CH_ZERO) begin
                        phase = prba_pkg::ST_N2_PREFIX;
                    end else begin
                        radix = prba_pkg::RADIX_DEC;
                        phase = prba_pkg::ST_N2_DIGITS;
                        take_digit(b);
                    end
                end
                prba_pkg::ST_N1_PREFIX, prba_pkg::ST_N2_PREFIX: begin
                    phase = (phase == prba_pkg::ST_N1_PREFIX) ?
                            prba_pkg::ST_N1_DIGITS : prba_pkg::ST_N2_DIGITS;
                    if (b == prba_pkg::CH_LX || b == prba_pkg::CH_UX) begin
                        radix = prba_pkg::RADIX_HEX;
                    end else begin
                        radix = prba_pkg::RADIX_OCT;
                        take_digit(b);
                    end
                end
                prba_pkg::ST_N1_DIGITS, prba_pkg::ST_N2_DIGITS: begin
                    take_digit(b);
                end
                default: begin
                    err = 1'b1;
                end
            endcase
        endfunction

        function void check_result(logic failed, t_value start_v, t_value stop_v);
            t_range_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: failed=%0b start=%0h stop=%0h",
                             failed, start_v, stop_v);
                return;
            end
            want = expected_q.pop_front();
            if (failed !== want.failed || start_v !== want.start_v ||
                stop_v !== want.stop_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0b/%0h/%0h got %0b/%0h/%0h",
                             want.failed, want.start_v, want.stop_v,
                             failed, start_v, stop_v);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_ready;
    logic [7:0]   i_char_code;
    logic         o_valid;
    logic         i_ready;
    logic         o_parse_failed;
    t_value       o_start_block;
    t_value       o_stop_block;

    range_scoreboard sb;
    logic [7:0]      arg_bytes[$];
    bit              tx_idle_on;
    bit              rx_idle_on;
    bit              hold_request;
    int              bytes_sent;
    int              cycle_count = 0;

    parse_block_range_argument #(
        .VALUE_WIDTH(VW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_parse_failed (o_parse_failed),
        .o_start_block  (o_start_block),
        .o_stop_block   (o_stop_block)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_arg();
        foreach (arg_bytes[k]) send_byte(arg_bytes[k]);
        send_byte(prba_pkg::CH_NUL);
    endtask

    task automatic send_text(string s);
        arg_bytes = {};
        for (int k = 0; k < s.len(); k++) arg_bytes.push_back(s[k]);
        send_arg();
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_value random_value();
        t_value v;
        case ($urandom_range(0, 3))
            0:       v = t_value'($urandom_range(0, 999));
            1:       v = {$urandom, $urandom};
            2:       v = ~t_value'($urandom_range(0, 20));
            default: v = t_value'({$urandom, $urandom}) >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    function automatic string number_text(t_value v, prba_pkg::t_radix rdx, bit upper);
        string s;
        case (rdx)
            prba_pkg::RADIX_DEC: s = $sformatf("%0d", v);
            prba_pkg::RADIX_OCT: s = {"0", $sformatf("%0o", v)};
            default: begin
                s = $sformatf("%0h", v);
                if (upper) s = {"0X", s.toupper()};
                else s = {"0x", s};
            end
        endcase
        return s;
    endfunction

    function automatic logic [7:0] digit_char(prba_pkg::t_radix rdx);
        int d;
        d = (rdx == prba_pkg::RADIX_HEX) ? $urandom_range(0, 15) :
            (rdx == prba_pkg::RADIX_OCT) ? $urandom_range(0, 7) : $urandom_range(0, 9);
        if (d < 10) return prba_pkg::CH_ZERO + 8'(d);
        return (($urandom_range(0, 1) == 1) ? prba_pkg::CH_UA : prba_pkg::CH_LA) +
               8'(d - 10);
    endfunction

    function automatic void add_number();
        prba_pkg::t_radix rdx;
        string            s;
        bit               upper;
        rdx   = prba_pkg::t_radix'($urandom_range(0, 2));
        upper = 1'($urandom_range(0, 1));
        s     = number_text(random_value(), rdx, upper);
        for (int k = 0; k < s.len(); k++) arg_bytes.push_back(s[k]);
        // one digit too many, usually an overflow for large values
        if ($urandom_range(0, 9) == 0) arg_bytes.push_back(digit_char(rdx));
    endfunction

    function automatic void build_range_arg();
        logic [7:0] ch;
        int         junk_len;
        arg_bytes = {};
        junk_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        repeat (junk_len) begin
            ch = 8'($urandom_range(1, 255));
            if (ch == prba_pkg::CH_COMMA) ch = prba_pkg::CH_UA;
            arg_bytes.push_back(ch);
        end
        arg_bytes.push_back(prba_pkg::CH_COMMA);
        add_number();
        arg_bytes.push_back(prba_pkg::CH_DASH);
        if ($urandom_range(0, 7) != 0) add_number();
        // corrupt one byte
        if ($urandom_range(0, 3) == 0)
            arg_bytes[$urandom_range(0, arg_bytes.size() - 1)] = 8'($urandom_range(1, 255));
    endfunction

    function automatic void build_noise();
        arg_bytes = {};
        repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 4))
                0:       arg_bytes.push_back(8'($urandom_range(1, 255)));
                1:       arg_bytes.push_back(prba_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                2:       arg_bytes.push_back(prba_pkg::CH_COMMA);
                3:       arg_bytes.push_back(prba_pkg::CH_DASH);
                default: arg_bytes.push_back(prba_pkg::CH_LX);
            endcase
        end
    endfunction

    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result(o_parse_failed, o_start_block, o_stop_block);
            if (stall_left > 0) begin
                stall_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            i_ready <= (stall_left == 0);
        end
    end

    initial begin
        string directed_args[];
        int    random_start;
        directed_args = '{
            "", ",5-7", "ab,x-1", ",0x-5", ",017-0X1f", ",09-1",
            ",18446744073709551615-0", ",18446744073709551616-1", ",1-",
            ",1-2-3", ",0xFFFFFFFFFFFFFFFF-0xfz", ",1-0x", ",1-8a", ",0-",
            ",-3", ",1777777777777777777777-0xZ", ",7-2000000000000000000000",
            ",0x10000000000000000-1", ",1A-2"
        };
        sb           = new();
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_request = 1'b0;
        bytes_sent   = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_char_code <= 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_args[k]) send_text(directed_args[k]);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text(",3-4");
        wait_for_results();

        // back the parser up while the receiver holds off
        hold_request = 1'b1;
        repeat (16) send_text(",12-34");
        wait_for_results();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if ($urandom_range(0, 15) == 0) begin
                tx_idle_on = $urandom_range(0, 2) != 0;
                rx_idle_on = $urandom_range(0, 2) != 0;
            end
            if (bytes_sent - random_start > RANDOM_BYTES - TAIL_BYTES) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if ($urandom_range(0, 39) == 0) wait_for_results();
            if ($urandom_range(0, 4) == 0) build_noise();
            else build_range_arg();
            send_arg();
        end

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/prba_pkg.sv
design/prba_front.sv
design/prba_queue.sv
design/prba_back.sv
design/parse_block_range_argument.sv
design/prba_checker.sv
tb/tb_top.sv
